@@ design/mgnes_pkg.sv @@
// ----------------------------------------------------------------------------
// mgnes_pkg: shared types and constants of the next event search unit
// Holds the default sizes, the transaction field layout, the operation codes,
// the node table entry layout and the controller to datapath interface.
// ----------------------------------------------------------------------------
package mgnes_pkg;

  // Default sizes of the graph tables.
  localparam int unsigned NODES_DEF   = 128;
  localparam int unsigned REGIONS_DEF = 16;

  // Fixed field widths of a transaction.
  localparam int unsigned NODE_W   = 7;
  localparam int unsigned CNT_W    = 2;
  localparam int unsigned REGION_W = 4;
  localparam int unsigned WRAP_W   = 30;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned RAD_W    = 64;
  localparam int unsigned OP_W     = 2;

  // Number of distinct raw node and region codes a transaction can carry.
  localparam int unsigned NODE_CODES   = 1 << NODE_W;
  localparam int unsigned REGION_CODES = 1 << REGION_W;

  // Input tdata layout, lowest bit first.
  localparam int unsigned IN_NODE_LSB   = 0;
  localparam int unsigned IN_CNT_LSB    = 7;
  localparam int unsigned IN_BND_LSB    = 9;
  localparam int unsigned IN_NB0_LSB    = 10;
  localparam int unsigned IN_NB1_LSB    = 17;
  localparam int unsigned IN_W0_LSB     = 24;
  localparam int unsigned IN_W1_LSB     = 56;
  localparam int unsigned IN_HASREG_LSB = 88;
  localparam int unsigned IN_REGION_LSB = 89;
  localparam int unsigned IN_WRAP_LSB   = 93;
  localparam int unsigned IN_RAD_LSB    = 123;
  localparam int unsigned IN_DATA_W     = 192;

  // Output tdata layout, lowest bit first.
  localparam int unsigned OUT_SLOT_LSB = 0;
  localparam int unsigned OUT_TIME_LSB = 1;
  localparam int unsigned OUT_DATA_W   = 72;

  // Time reported when no collision is pending.
  localparam logic [RAD_W-1:0] NO_EVENT = 64'h7FFF_FFFF_FFFF_FFFF;

  // Largest meaningful neighbour count.
  localparam logic [CNT_W-1:0] MAX_SLOTS = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_WR_NODE   = 2'd0,
    OP_WR_REGION = 2'd1,
    OP_QUERY     = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  // One node table entry: everything a node owns.
  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic                bnd;
    logic                has_region;
    logic [REGION_W-1:0] region;
    logic [WRAP_W-1:0]   wrapped;
    logic [NODE_W-1:0]   nb0;
    logic [NODE_W-1:0]   nb1;
    logic [WEIGHT_W-1:0] w0;
    logic [WEIGHT_W-1:0] w1;
  } node_ent_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_node;   // write the node table from the accepted transaction
    logic wr_region; // write the region radius table
    logic rd_in;     // node table read address comes from the input
    logic cap_own;   // capture the queried node's entry and reset the search
    logic rad1_ld;   // load the queried node's radius
    logic sub_bnd;   // form the boundary candidate
    logic cap_nb;    // capture the current neighbour's entry
    logic rad2_ld;   // load the neighbour's radius
    logic sub_nb;    // form the neighbour candidate
    logic cmp;       // compare the candidate and step to the next slot
    logic out_ld;    // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bnd_case;  // slot 0 is a used boundary slot
    logic more;      // the current slot is a used slot
    logic more_next; // the slot after the current one is used
    logic out_free;  // the result register can take a new result
  } dp_sts_t;

endpackage

@@ design/matching_graph_next_event_search_unit.sv @@
// ----------------------------------------------------------------------------
// matching_graph_next_event_search_unit: earliest collision on a small graph
// A query returns the earliest collision time among a node's two neighbour
// slots, one of which may be the boundary; writes fill the graph tables.
// ----------------------------------------------------------------------------
// Sequence: a write is performed in the same cycle in which it is accepted.
// A query makes a chain of registered reads (node entry, region radius,
// neighbour entry, its radius): it forms a candidate for a used boundary slot
// and for each used neighbour slot, comparing them in turn. No new transaction
// is taken until the query result is loaded, which waits while an old one is pending.
// Reset: rst clears the sequencer and the result valid flag; tables are left.
module matching_graph_next_event_search_unit #(
  parameter int unsigned NODES   = mgnes_pkg::NODES_DEF,
  parameter int unsigned REGIONS = mgnes_pkg::REGIONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // From bit 0: node(7), neighbor_count(2), boundary_first(1), neighbor0(7),
  // neighbor1(7), weight0(32), weight1(32), has_region(1), region(4),
  // wrapped_radius(30), radius_value(64), zero padding(5).
  input  logic [mgnes_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // From bit 0: op(2).
  input  logic [mgnes_pkg::OP_W-1:0]         s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // From bit 0: neighbor_slot(1), event_time(64), zero padding(7).
  output logic [mgnes_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // From bit 0: event_found(1).
  output logic                               m_axis_tuser
);

  mgnes_pkg::dp_cmd_t cmd;
  mgnes_pkg::dp_sts_t sts;
  mgnes_pkg::op_t     op;

  logic                              out_found;
  logic                              out_slot;
  logic [mgnes_pkg::RAD_W-1:0]       res_time;

  // The operation code travels in tuser; anything the enum does not name as
  // a write or a query is simply ignored by the sequencer.
  assign op = mgnes_pkg::op_t'(s_axis_tuser);

  // The sequencer only takes a transaction while it is idle. A result waiting
  // in the output register does not block acceptance; only a query that
  // finishes while the previous result is still pending waits for it.
  mgnes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (op),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Field slices of the input transaction are handed straight to the
  // datapath, which holds the tables and the running minimum.
  mgnes_dp #(
    .NODES   (NODES),
    .REGIONS (REGIONS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_node       (s_axis_tdata[mgnes_pkg::IN_NODE_LSB +: mgnes_pkg::NODE_W]),
    .in_count      (s_axis_tdata[mgnes_pkg::IN_CNT_LSB +: mgnes_pkg::CNT_W]),
    .in_bnd        (s_axis_tdata[mgnes_pkg::IN_BND_LSB]),
    .in_nb0        (s_axis_tdata[mgnes_pkg::IN_NB0_LSB +: mgnes_pkg::NODE_W]),
    .in_nb1        (s_axis_tdata[mgnes_pkg::IN_NB1_LSB +: mgnes_pkg::NODE_W]),
    .in_w0         (s_axis_tdata[mgnes_pkg::IN_W0_LSB +: mgnes_pkg::WEIGHT_W]),
    .in_w1         (s_axis_tdata[mgnes_pkg::IN_W1_LSB +: mgnes_pkg::WEIGHT_W]),
    .in_has_region (s_axis_tdata[mgnes_pkg::IN_HASREG_LSB]),
    .in_region     (s_axis_tdata[mgnes_pkg::IN_REGION_LSB +: mgnes_pkg::REGION_W]),
    .in_wrapped    (s_axis_tdata[mgnes_pkg::IN_WRAP_LSB +: mgnes_pkg::WRAP_W]),
    .in_radius     (s_axis_tdata[mgnes_pkg::IN_RAD_LSB +: mgnes_pkg::RAD_W]),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_found     (out_found),
    .out_slot      (out_slot),
    .res_time      (res_time)
  );

  // Pack the result transaction; the padding bits are tied to zero.
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[mgnes_pkg::OUT_SLOT_LSB]                        = out_slot;
    m_axis_tdata[mgnes_pkg::OUT_TIME_LSB +: mgnes_pkg::RAD_W]    = res_time;
  end

  assign m_axis_tuser = out_found;

endmodule

@@ design/mgnes_ctrl.sv @@
// ----------------------------------------------------------------------------
// mgnes_ctrl: sequencer of the next event search unit
// Steps a query through the node, radius, candidate and compare phases and
// issues table writes for the two write operations.
// ----------------------------------------------------------------------------
module mgnes_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  mgnes_pkg::op_t      in_op,
  output logic                in_ready,
  input  mgnes_pkg::dp_sts_t  sts,
  output mgnes_pkg::dp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_OWN_ENT = 10'b00_0000_0010,
    ST_OWN_RAD = 10'b00_0000_0100,
    ST_BND     = 10'b00_0000_1000,
    ST_NB_RD   = 10'b00_0001_0000,
    ST_NB_ENT  = 10'b00_0010_0000,
    ST_NB_RAD  = 10'b00_0100_0000,
    ST_NB_SUB  = 10'b00_1000_0000,
    ST_CMP     = 10'b01_0000_0000,
    ST_DONE    = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = !rst && (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.rd_in     = 1'b1;
        cmd.wr_node   = accept && (in_op == mgnes_pkg::OP_WR_NODE);
        cmd.wr_region = accept && (in_op == mgnes_pkg::OP_WR_REGION);
        if (accept && (in_op == mgnes_pkg::OP_QUERY)) begin
          state_next = ST_OWN_ENT;
        end
      end
      ST_OWN_ENT: begin
        cmd.cap_own = 1'b1;
        state_next  = ST_OWN_RAD;
      end
      ST_OWN_RAD: begin
        cmd.rad1_ld = 1'b1;
        priority if (sts.bnd_case) begin
          state_next = ST_BND;
        end else if (sts.more) begin
          state_next = ST_NB_ENT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_BND: begin
        cmd.sub_bnd = 1'b1;
        state_next  = ST_CMP;
      end
      ST_NB_RD: begin
        state_next = ST_NB_ENT;
      end
      ST_NB_ENT: begin
        cmd.cap_nb = 1'b1;
        state_next = ST_NB_RAD;
      end
      ST_NB_RAD: begin
        cmd.rad2_ld = 1'b1;
        state_next  = ST_NB_SUB;
      end
      ST_NB_SUB: begin
        cmd.sub_nb = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = sts.more_next ? ST_NB_RD : ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/mgnes_dp.sv @@
// ----------------------------------------------------------------------------
// mgnes_dp: datapath of the next event search unit
// Holds the node and region radius tables, the radius adder, the candidate
// subtractor, the running minimum and the result register.
// ----------------------------------------------------------------------------
module mgnes_dp #(
  parameter int unsigned NODES   = mgnes_pkg::NODES_DEF,
  parameter int unsigned REGIONS = mgnes_pkg::REGIONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mgnes_pkg::dp_cmd_t                  cmd,
  output mgnes_pkg::dp_sts_t                  sts,
  input  logic [mgnes_pkg::NODE_W-1:0]        in_node,
  input  logic [mgnes_pkg::CNT_W-1:0]         in_count,
  input  logic                                in_bnd,
  input  logic [mgnes_pkg::NODE_W-1:0]        in_nb0,
  input  logic [mgnes_pkg::NODE_W-1:0]        in_nb1,
  input  logic [mgnes_pkg::WEIGHT_W-1:0]      in_w0,
  input  logic [mgnes_pkg::WEIGHT_W-1:0]      in_w1,
  input  logic                                in_has_region,
  input  logic [mgnes_pkg::REGION_W-1:0]      in_region,
  input  logic [mgnes_pkg::WRAP_W-1:0]        in_wrapped,
  input  logic [mgnes_pkg::RAD_W-1:0]         in_radius,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_found,
  output logic                                out_slot,
  output logic [mgnes_pkg::RAD_W-1:0]         res_time
);

  localparam int unsigned NIW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned RIW = (REGIONS > 1) ? $clog2(REGIONS) : 1;

  // Reduction of raw indices into the table depths.
  logic [NIW-1:0] node_mod [mgnes_pkg::NODE_CODES];
  logic [RIW-1:0] reg_mod  [mgnes_pkg::REGION_CODES];

  for (genvar v = 0; v < mgnes_pkg::NODE_CODES; v++) begin : g_node_mod
    assign node_mod[v] = NIW'(v % NODES);
  end
  for (genvar v = 0; v < mgnes_pkg::REGION_CODES; v++) begin : g_reg_mod
    assign reg_mod[v] = RIW'(v % REGIONS);
  end

  // Tables.
  mgnes_pkg::node_ent_t            node_mem [NODES];
  logic [mgnes_pkg::RAD_W-1:0]     region_mem [REGIONS];
  mgnes_pkg::node_ent_t            node_q;
  logic [mgnes_pkg::RAD_W-1:0]     region_q;
  mgnes_pkg::node_ent_t            wr_ent;
  logic [NIW-1:0]                  node_raddr;

  // Search registers.
  logic [mgnes_pkg::CNT_W-1:0]     cnt;
  logic                            bnd;
  logic [mgnes_pkg::NODE_W-1:0]    own_nb0;
  logic [mgnes_pkg::NODE_W-1:0]    own_nb1;
  logic [mgnes_pkg::WEIGHT_W-1:0]  own_w0;
  logic [mgnes_pkg::WEIGHT_W-1:0]  own_w1;
  logic [mgnes_pkg::REGION_W:0]    own_reg;
  logic [mgnes_pkg::REGION_W:0]    nb_reg;
  logic                            ent_has_region;
  logic [mgnes_pkg::WRAP_W-1:0]    ent_wrapped;
  logic [mgnes_pkg::RAD_W-1:0]     rad1;
  logic [mgnes_pkg::RAD_W-1:0]     rad2;
  logic [mgnes_pkg::RAD_W-1:0]     rad_calc;
  logic [mgnes_pkg::RAD_W-1:0]     rad1c;
  logic [mgnes_pkg::RAD_W-1:0]     rad2c;
  logic [mgnes_pkg::RAD_W-1:0]     w_cur;
  logic [mgnes_pkg::RAD_W-1:0]     diff;
  logic [mgnes_pkg::CNT_W-1:0]     slot;
  logic [mgnes_pkg::RAD_W-1:0]     cand_t;
  logic                            cand_ok;
  logic [mgnes_pkg::RAD_W-1:0]     best;
  logic                            best_slot;
  logic                            found;
  logic                            growing;

  always_comb begin
    wr_ent            = '0;
    wr_ent.count      = in_count;
    wr_ent.bnd        = in_bnd;
    wr_ent.has_region = in_has_region;
    wr_ent.region     = in_has_region ? in_region : '0;
    wr_ent.wrapped    = in_wrapped;
    wr_ent.nb0        = in_nb0;
    wr_ent.nb1        = in_nb1;
    wr_ent.w0         = in_w0;
    wr_ent.w1         = in_w1;
  end

  assign node_raddr = cmd.rd_in ? node_mod[in_node]
                                : node_mod[slot[0] ? own_nb1 : own_nb0];

  always_ff @(posedge clk) begin
    if (cmd.wr_node) begin
      node_mem[node_mod[in_node]] <= wr_ent;
    end
    node_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_region) begin
      region_mem[reg_mod[in_region]] <= in_radius;
    end
    region_q <= region_mem[reg_mod[node_q.region]];
  end

  // Radius of the captured entry.
  assign rad_calc = ent_has_region
                  ? region_q + mgnes_pkg::RAD_W'({ent_wrapped, 2'b00})
                  : '0;

  assign rad1c   = {rad1[mgnes_pkg::RAD_W-1:2], 2'b00};
  assign rad2c   = {rad2[mgnes_pkg::RAD_W-1:2], 2'b00};
  assign growing = rad1[0];
  assign w_cur   = mgnes_pkg::RAD_W'(slot[0] ? own_w1 : own_w0);
  assign diff    = w_cur - rad1c - rad2c;

  always_ff @(posedge clk) begin
    if (cmd.cap_own) begin
      cnt     <= (node_q.count > mgnes_pkg::MAX_SLOTS) ? mgnes_pkg::MAX_SLOTS
                                                      : node_q.count;
      bnd     <= node_q.bnd;
      own_nb0 <= node_q.nb0;
      own_nb1 <= node_q.nb1;
      own_w0  <= node_q.w0;
      own_w1  <= node_q.w1;
      own_reg <= {node_q.has_region, node_q.region};
    end
    if (cmd.cap_nb) begin
      nb_reg <= {node_q.has_region, node_q.region};
    end
    if (cmd.cap_own || cmd.cap_nb) begin
      ent_has_region <= node_q.has_region;
      ent_wrapped    <= node_q.wrapped;
    end
    if (cmd.rad1_ld) begin
      rad1 <= rad_calc;
    end
    if (cmd.rad2_ld) begin
      rad2 <= rad_calc;
    end
    if (cmd.sub_bnd) begin
      cand_t  <= mgnes_pkg::RAD_W'(own_w0) - rad1c;
      cand_ok <= growing;
    end
    if (cmd.sub_nb) begin
      if (growing) begin
        cand_ok <= (own_reg != nb_reg) && !rad2[1];
        cand_t  <= rad2[0] ? (diff >> 1) : diff;
      end else begin
        cand_ok <= rad2[0];
        cand_t  <= diff;
      end
    end
  end

  // Running minimum; the strict compare keeps the lower slot on a tie.
  always_ff @(posedge clk) begin
    if (cmd.cap_own) begin
      slot      <= '0;
      best      <= mgnes_pkg::NO_EVENT;
      best_slot <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.cmp) begin
      slot <= slot + 2'd1;
      if (cand_ok && (cand_t < best)) begin
        best      <= cand_t;
        best_slot <= slot[0];
        found     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_found <= found;
      out_slot  <= found && best_slot;
      res_time  <= best;
    end
  end

  assign sts.bnd_case  = bnd && (cnt != '0);
  assign sts.more      = slot < cnt;
  assign sts.more_next = (slot + 2'd1) < cnt;
  assign sts.out_free  = !out_valid || out_ready;

endmodule
